[design/cossim_pkg.sv]
// ----------------------------------------------------------------------------
// cossim_pkg
// Shared widths, microcode encoding and control program of the cosine
// similarity block.
// ----------------------------------------------------------------------------
`default_nettype none

package cossim_pkg;

  localparam int ELEMENT_WIDTH = 16;
  localparam int PROD_WIDTH    = 2 * ELEMENT_WIDTH;
  localparam int DOT_WIDTH     = 45;
  localparam int SQUARE_WIDTH  = 44;
  localparam int ROOT_WIDTH    = SQUARE_WIDTH / 2;
  localparam int REM_WIDTH     = ROOT_WIDTH + 2;
  localparam int QUOT_WIDTH    = 15;
  localparam int COSINE_WIDTH  = 16;
  localparam int FRAC_BITS     = 14;
  localparam int ONE_Q14       = 1 << FRAC_BITS;
  localparam int STEP_WIDTH    = 3;
  localparam int CNT_WIDTH     = 5;

  typedef logic [STEP_WIDTH-1:0] step_t;
  typedef logic [CNT_WIDTH-1:0]  cnt_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    JC_NEXT,     // fall through
    JC_ON_LAST,  // leave when the last word is taken, else hold
    JC_LOOP,     // back to target while the loop count is nonzero
    JC_GOTO
  } jump_t;

  typedef struct packed {
    dp_op_t op;
    jump_t  jc;
    step_t  target;
    logic   cnt_load;
    cnt_t   cnt_init;
  } uword_t;

  typedef struct packed {
    dp_op_t op;
    logic   idle;
  } ctl_t;

  localparam step_t ST_ACC      = 3'd0;
  localparam step_t ST_SQ_INIT  = 3'd1;
  localparam step_t ST_SQ_STEP  = 3'd2;
  localparam step_t ST_MUL      = 3'd3;
  localparam step_t ST_DIV_INIT = 3'd4;
  localparam step_t ST_DIV_STEP = 3'd5;
  localparam step_t ST_EMIT     = 3'd6;

  localparam cnt_t SQ_LOOPS  = CNT_WIDTH'(ROOT_WIDTH - 1);
  localparam cnt_t DIV_LOOPS = CNT_WIDTH'(QUOT_WIDTH - 2);

  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    case (s)
      ST_ACC:      w = '{OP_IDLE,     JC_ON_LAST, ST_SQ_INIT,  1'b0, '0};
      ST_SQ_INIT:  w = '{OP_SQ_INIT,  JC_NEXT,    ST_ACC,      1'b1, SQ_LOOPS};
      ST_SQ_STEP:  w = '{OP_SQ_STEP,  JC_LOOP,    ST_SQ_STEP,  1'b0, '0};
      ST_MUL:      w = '{OP_MUL,      JC_NEXT,    ST_ACC,      1'b0, '0};
      ST_DIV_INIT: w = '{OP_DIV_INIT, JC_NEXT,    ST_ACC,      1'b1, DIV_LOOPS};
      ST_DIV_STEP: w = '{OP_DIV_STEP, JC_LOOP,    ST_DIV_STEP, 1'b0, '0};
      ST_EMIT:     w = '{OP_EMIT,     JC_GOTO,    ST_ACC,      1'b0, '0};
      default:     w = '{OP_IDLE,     JC_GOTO,    ST_ACC,      1'b0, '0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[design/cossim_mac.sv]
// ----------------------------------------------------------------------------
// cossim_mac
// Saturating accumulators for the dot product and both sums of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module cossim_mac
  import cossim_pkg::*;
(
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               accept,
  input  wire logic signed [ELEMENT_WIDTH-1:0] first_el,
  input  wire logic signed [ELEMENT_WIDTH-1:0] second_el,
  input  wire ctl_t                         ctl,
  output logic signed [DOT_WIDTH-1:0]       dot,
  output logic [SQUARE_WIDTH-1:0]           sq1,
  output logic [SQUARE_WIDTH-1:0]           sq2
);

  localparam logic signed [DOT_WIDTH-1:0] DOT_HI = {1'b0, {(DOT_WIDTH-1){1'b1}}};
  localparam logic signed [DOT_WIDTH-1:0] DOT_LO = {1'b1, {(DOT_WIDTH-1){1'b0}}};

  logic signed [DOT_WIDTH-1:0] dot_r, dot_nxt;
  logic [SQUARE_WIDTH-1:0]     sq1_r, sq1_nxt, sq2_r, sq2_nxt;
  logic signed [PROD_WIDTH-1:0] prod_ab, prod_aa, prod_bb;
  logic signed [DOT_WIDTH:0]   dot_sum;
  logic [SQUARE_WIDTH:0]       sq1_sum, sq2_sum;

  always_comb begin
    prod_ab = first_el * second_el;
    prod_aa = first_el * first_el;
    prod_bb = second_el * second_el;
    dot_sum = (DOT_WIDTH+1)'(dot_r) + (DOT_WIDTH+1)'(prod_ab);
    // squares are never negative, so the low bits carry the magnitude
    sq1_sum = {1'b0, sq1_r} + (SQUARE_WIDTH+1)'(prod_aa[PROD_WIDTH-2:0]);
    sq2_sum = {1'b0, sq2_r} + (SQUARE_WIDTH+1)'(prod_bb[PROD_WIDTH-2:0]);

    dot_nxt = dot_r;
    sq1_nxt = sq1_r;
    sq2_nxt = sq2_r;
    if (ctl.op == OP_EMIT) begin
      dot_nxt = '0;
      sq1_nxt = '0;
      sq2_nxt = '0;
    end else if (accept) begin
      if (dot_sum[DOT_WIDTH] != dot_sum[DOT_WIDTH-1]) begin
        dot_nxt = dot_sum[DOT_WIDTH] ? DOT_LO : DOT_HI;
      end else begin
        dot_nxt = dot_sum[DOT_WIDTH-1:0];
      end
      sq1_nxt = sq1_sum[SQUARE_WIDTH] ? '1 : sq1_sum[SQUARE_WIDTH-1:0];
      sq2_nxt = sq2_sum[SQUARE_WIDTH] ? '1 : sq2_sum[SQUARE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      sq1_r <= '0;
      sq2_r <= '0;
    end else begin
      dot_r <= dot_nxt;
      sq1_r <= sq1_nxt;
      sq2_r <= sq2_nxt;
    end
  end

  assign dot = dot_r;
  assign sq1 = sq1_r;
  assign sq2 = sq2_r;

endmodule

`default_nettype wire

[design/cossim_seq.sv]
// ----------------------------------------------------------------------------
// cossim_seq
// Microcode sequencer: step counter, loop counter and jump logic over the
// control program held in the package.
// ----------------------------------------------------------------------------
`default_nettype none

module cossim_seq
  import cossim_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  start,
  input  wire  last_el,
  output ctl_t ctl
);

  step_t  step_r, step_nxt;
  cnt_t   cnt_r, cnt_nxt;
  uword_t uw;

  always_comb begin
    uw       = ucode_rom(step_r);
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    case (uw.jc)
      JC_NEXT:    step_nxt = step_r + 1'b1;
      JC_ON_LAST: step_nxt = (start && last_el) ? uw.target : step_r;
      JC_LOOP: begin
        if (cnt_r != '0) begin
          step_nxt = uw.target;
          cnt_nxt  = cnt_r - 1'b1;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      JC_GOTO:    step_nxt = uw.target;
      default:    step_nxt = ST_ACC;
    endcase
    if (uw.cnt_load) begin
      cnt_nxt = uw.cnt_init;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_ACC;
      cnt_r  <= '0;
    end else begin
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign ctl.op   = uw.op;
  assign ctl.idle = (step_r == ST_ACC);

endmodule

`default_nettype wire

[design/cossim_dp.sv]
// ----------------------------------------------------------------------------
// cossim_dp
// Finishing datapath: two digit-by-digit square roots, root product, bit
// serial restoring divide, saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cossim_dp
  import cossim_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire ctl_t                    ctl,
  input  wire logic signed [DOT_WIDTH-1:0] dot,
  input  wire logic [SQUARE_WIDTH-1:0] sq1,
  input  wire logic [SQUARE_WIDTH-1:0] sq2,
  output logic                         out_valid,
  output logic signed [COSINE_WIDTH-1:0] out_cosine,
  output logic                         out_status
);

  localparam logic [QUOT_WIDTH-1:0] Q_ONE = QUOT_WIDTH'(ONE_Q14);

  logic [SQUARE_WIDTH-1:0] x1_r, x1_nxt, x2_r, x2_nxt;
  logic [REM_WIDTH-1:0]    rem1_r, rem1_nxt, rem2_r, rem2_nxt;
  logic [ROOT_WIDTH-1:0]   root1_r, root1_nxt, root2_r, root2_nxt;
  logic [SQUARE_WIDTH-1:0] denom_r, denom_nxt;
  logic [DOT_WIDTH-1:0]    mag_r, mag_nxt, drem_r, drem_nxt;
  logic [QUOT_WIDTH-1:0]   quot_r, quot_nxt;
  logic                    neg_r, neg_nxt, zero_r, zero_nxt, sat_r, sat_nxt;
  logic                    valid_r, valid_nxt;
  logic signed [COSINE_WIDTH-1:0] cos_r, cos_nxt;
  logic                    status_r, status_nxt;

  logic [REM_WIDTH+1:0]    sh1, sh2, trial1, trial2;
  logic [DOT_WIDTH-1:0]    dsh, den_ext;
  logic                    dbit;
  logic [QUOT_WIDTH-1:0]   qmag;
  logic [COSINE_WIDTH-1:0] qext;

  always_comb begin
    // one root digit per step: bring down two radicand bits, try 4r+1
    sh1    = {rem1_r, x1_r[SQUARE_WIDTH-1 -: 2]};
    sh2    = {rem2_r, x2_r[SQUARE_WIDTH-1 -: 2]};
    trial1 = (REM_WIDTH+2)'({root1_r, 2'b01});
    trial2 = (REM_WIDTH+2)'({root2_r, 2'b01});

    den_ext = {1'b0, denom_r};
    dsh     = {drem_r[DOT_WIDTH-2:0], 1'b0};
    dbit    = (dsh >= den_ext);

    x1_nxt    = x1_r;
    x2_nxt    = x2_r;
    rem1_nxt  = rem1_r;
    rem2_nxt  = rem2_r;
    root1_nxt = root1_r;
    root2_nxt = root2_r;
    denom_nxt = denom_r;
    mag_nxt   = mag_r;
    drem_nxt  = drem_r;
    quot_nxt  = quot_r;
    neg_nxt   = neg_r;
    zero_nxt  = zero_r;
    sat_nxt   = sat_r;
    valid_nxt = 1'b0;
    cos_nxt   = cos_r;
    status_nxt = status_r;

    qmag = sat_r ? Q_ONE : ((quot_r > Q_ONE) ? Q_ONE : quot_r);
    qext = COSINE_WIDTH'(qmag);

    case (ctl.op)
      OP_SQ_INIT: begin
        x1_nxt    = sq1;
        x2_nxt    = sq2;
        rem1_nxt  = '0;
        rem2_nxt  = '0;
        root1_nxt = '0;
        root2_nxt = '0;
      end
      OP_SQ_STEP: begin
        x1_nxt = {x1_r[SQUARE_WIDTH-3:0], 2'b00};
        x2_nxt = {x2_r[SQUARE_WIDTH-3:0], 2'b00};
        if (sh1 >= trial1) begin
          rem1_nxt  = REM_WIDTH'(sh1 - trial1);
          root1_nxt = {root1_r[ROOT_WIDTH-2:0], 1'b1};
        end else begin
          rem1_nxt  = REM_WIDTH'(sh1);
          root1_nxt = {root1_r[ROOT_WIDTH-2:0], 1'b0};
        end
        if (sh2 >= trial2) begin
          rem2_nxt  = REM_WIDTH'(sh2 - trial2);
          root2_nxt = {root2_r[ROOT_WIDTH-2:0], 1'b1};
        end else begin
          rem2_nxt  = REM_WIDTH'(sh2);
          root2_nxt = {root2_r[ROOT_WIDTH-2:0], 1'b0};
        end
      end
      OP_MUL: begin
        denom_nxt = SQUARE_WIDTH'(root1_r) * SQUARE_WIDTH'(root2_r);
        neg_nxt   = dot[DOT_WIDTH-1];
        mag_nxt   = dot[DOT_WIDTH-1] ? DOT_WIDTH'(-dot) : DOT_WIDTH'(dot);
        zero_nxt  = (root1_r == '0) || (root2_r == '0);
      end
      OP_DIV_INIT: begin
        // quotient at or above 2.0 needs no divide, it saturates
        sat_nxt = (mag_r >= {denom_r, 1'b0});
        if (mag_r >= den_ext) begin
          drem_nxt = mag_r - den_ext;
          quot_nxt = QUOT_WIDTH'(1);
        end else begin
          drem_nxt = mag_r;
          quot_nxt = '0;
        end
      end
      OP_DIV_STEP: begin
        drem_nxt = dbit ? (dsh - den_ext) : dsh;
        quot_nxt = {quot_r[QUOT_WIDTH-2:0], dbit};
      end
      OP_EMIT: begin
        valid_nxt = 1'b1;
        if (zero_r) begin
          cos_nxt    = '0;
          status_nxt = 1'b1;
        end else begin
          cos_nxt    = neg_r ? -$signed(qext) : $signed(qext);
          status_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    x1_r     <= x1_nxt;
    x2_r     <= x2_nxt;
    rem1_r   <= rem1_nxt;
    rem2_r   <= rem2_nxt;
    root1_r  <= root1_nxt;
    root2_r  <= root2_nxt;
    denom_r  <= denom_nxt;
    mag_r    <= mag_nxt;
    drem_r   <= drem_nxt;
    quot_r   <= quot_nxt;
    neg_r    <= neg_nxt;
    zero_r   <= zero_nxt;
    sat_r    <= sat_nxt;
    cos_r    <= cos_nxt;
    status_r <= status_nxt;
  end

  assign out_valid  = valid_r;
  assign out_cosine = cos_r;
  assign out_status = status_r;

endmodule

`default_nettype wire

[design/cosine_similarity.sv]
// ----------------------------------------------------------------------------
// cosine_similarity
// Streams two vectors one element pair per word and reports their cosine.
// ----------------------------------------------------------------------------
// Input channel: a word (in_first_element, in_second_element,
// in_last_element) is taken at a rising edge with start high and busy low.
// Words without the last flag only accumulate and are taken in every cycle that start is high.
// A word with the last flag raises busy while the microcode runs:
// 1 setup, 22 square-root digit steps (both roots side by side),
// 1 root multiply, 1 divide setup, 14 divide steps and 1 result step.
// The result appears on out_cosine/out_status with out_valid high for one
// cycle, in the cycle where busy drops again; a new word can be taken in
// that same cycle. Throughput is one word per cycle inside a vector; the
// root and divide iterations after each vector hold off new words.
// out_cosine is signed Q2.14, truncated and held to +/-1.0; out_status set
// means one vector had zero norm and out_cosine is zero.
// The receiver cannot stall; out_valid is a strobe.
// Synchronous reset clears the accumulators and returns the sequencer to
// its idle step; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_similarity
  import cossim_pkg::*;
(
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire logic signed [ELEMENT_WIDTH-1:0] in_first_element,
  input  wire logic signed [ELEMENT_WIDTH-1:0] in_second_element,
  input  wire                               in_last_element,
  output logic                              out_valid,
  output logic signed [COSINE_WIDTH-1:0]    out_cosine,
  output logic                              out_status
);

  ctl_t                        ctl;
  logic                        accept;
  logic signed [DOT_WIDTH-1:0] dot;
  logic [SQUARE_WIDTH-1:0]     sq1, sq2;

  assign busy   = !ctl.idle;
  assign accept = start && ctl.idle;

  cossim_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .last_el (in_last_element),
    .ctl     (ctl)
  );

  cossim_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .first_el  (in_first_element),
    .second_el (in_second_element),
    .ctl       (ctl),
    .dot       (dot),
    .sq1       (sq1),
    .sq2       (sq2)
  );

  cossim_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .dot        (dot),
    .sq1        (sq1),
    .sq2        (sq2),
    .out_valid  (out_valid),
    .out_cosine (out_cosine),
    .out_status (out_status)
  );

endmodule

`default_nettype wire

[design/cossim_checker.sv]
// ----------------------------------------------------------------------------
// cossim_checker
// Port-level checks on the cosine similarity block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cossim_checker
  import cossim_pkg::*;
(
  input wire                          clk,
  input wire                          rst_n,
  input wire                          start,
  input wire                          busy,
  input wire                          in_last_element,
  input wire                          out_valid,
  input wire logic signed [COSINE_WIDTH-1:0] out_cosine,
  input wire                          out_status
);

  localparam logic signed [COSINE_WIDTH-1:0] COS_MAX = COSINE_WIDTH'(ONE_Q14);
  localparam logic signed [COSINE_WIDTH-1:0] COS_MIN = -COSINE_WIDTH'(ONE_Q14);

  // a last word starts the finishing program
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_element |=> busy)
    else $error("last word did not raise busy");

  // the result comes out as the block goes idle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_cosine == '0)
    else $error("zero-norm result with nonzero cosine");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cosine <= COS_MAX) && (out_cosine >= COS_MIN))
    else $error("cosine outside +/-1.0");

endmodule

bind cosine_similarity cossim_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_last_element (in_last_element),
  .out_valid       (out_valid),
  .out_cosine      (out_cosine),
  .out_status      (out_status)
);

`default_nettype wire

[tb/tb_cosine_similarity.sv]
// ----------------------------------------------------------------------------
// tb_cosine_similarity
// Streams element-pair words into the cosine similarity block. A behavioral
// model folds every accepted word into its own dot product and sums of
// squares, and a monitor checks each cosine/status strobe against the oldest
// predicted result. Covers extremes, zero norm, root-rounding saturation
// and random vectors under varying amounts of sender idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cosine_similarity;
  import cossim_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_PER_PH  = 250;

  typedef struct {
    logic signed [ELEMENT_WIDTH-1:0] first;
    logic signed [ELEMENT_WIDTH-1:0] second;
    logic                            last;
  } pair_t;

  typedef struct {
    logic signed [COSINE_WIDTH-1:0] cosine;
    logic                           status;
  } cos_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             start = 1'b0;
  logic                             busy;
  logic signed [ELEMENT_WIDTH-1:0]  in_first_element = '0;
  logic signed [ELEMENT_WIDTH-1:0]  in_second_element = '0;
  logic                             in_last_element = 1'b0;
  logic                             out_valid;
  logic signed [COSINE_WIDTH-1:0]   out_cosine;
  logic                             out_status;

  pair_t       pair_queue[$];
  cos_result_t pending_cosines[$];
  int          sender_idle_pct = 0;
  int          fail_count = 0;
  int          stall_cycles = 0;

  // running sums of the model, widths held by saturation below
  longint          dot_sum = 0;
  longint unsigned first_sq_sum = 0;
  longint unsigned second_sq_sum = 0;

  cosine_similarity dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_first_element (in_first_element),
    .in_second_element(in_second_element),
    .in_last_element  (in_last_element),
    .out_valid        (out_valid),
    .out_cosine       (out_cosine),
    .out_status       (out_status)
  );

  always #1 clk = ~clk;

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int k = SQUARE_WIDTH / 2; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  task automatic fold_pair(logic signed [ELEMENT_WIDTH-1:0] a,
                           logic signed [ELEMENT_WIDTH-1:0] b, logic last);
    longint          av, bv, dot_hi, dot_lo;
    longint unsigned sq_limit, ma, mb, r1, r2, mag, q;
    cos_result_t     res;
    av = longint'(a);
    bv = longint'(b);
    dot_hi = (64'sd1 <<< (DOT_WIDTH - 1)) - 1;
    dot_lo = -dot_hi - 1;
    sq_limit = (64'd1 << SQUARE_WIDTH) - 1;
    ma = (av < 0) ? -av : av;
    mb = (bv < 0) ? -bv : bv;
    dot_sum = dot_sum + av * bv;
    if (dot_sum > dot_hi) dot_sum = dot_hi;
    if (dot_sum < dot_lo) dot_sum = dot_lo;
    first_sq_sum = first_sq_sum + ma * ma;
    if (first_sq_sum > sq_limit) first_sq_sum = sq_limit;
    second_sq_sum = second_sq_sum + mb * mb;
    if (second_sq_sum > sq_limit) second_sq_sum = sq_limit;
    if (!last) return;
    r1 = floor_root(first_sq_sum);
    r2 = floor_root(second_sq_sum);
    if (r1 == 0 || r2 == 0) begin
      res.cosine = '0;
      res.status = 1'b1;
    end else begin
      mag = (dot_sum < 0) ? -dot_sum : dot_sum;
      q = (mag * ONE_Q14) / (r1 * r2);
      if (q > ONE_Q14) q = ONE_Q14;
      res.cosine = (dot_sum < 0) ? -COSINE_WIDTH'(q) : COSINE_WIDTH'(q);
      res.status = 1'b0;
    end
    pending_cosines.push_back(res);
    dot_sum = 0;
    first_sq_sum = 0;
    second_sq_sum = 0;
  endtask

  function automatic logic signed [ELEMENT_WIDTH-1:0] pick_element(int flavor);
    int extremes[5] = '{-32768, 32767, -1, 0, 1};
    case (flavor)
      0:       return ELEMENT_WIDTH'($urandom());
      1:       return ELEMENT_WIDTH'(int'($urandom_range(16, 0)) - 8);
      default: return ELEMENT_WIDTH'(extremes[$urandom_range(4, 0)]);
    endcase
  endfunction

  task automatic add_pair(int a, int b, logic last);
    pair_t p;
    p.first = ELEMENT_WIDTH'(a);
    p.second = ELEMENT_WIDTH'(b);
    p.last = last;
    pair_queue.push_back(p);
  endtask

  // one random vector; the shape picks how the two vectors relate
  task automatic add_random_vector(output int len);
    int   shape, flavor;
    logic signed [ELEMENT_WIDTH-1:0] a, b, jitter;
    logic neg;
    len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    shape = $urandom_range(5, 0);
    flavor = $urandom_range(2, 0);
    neg = 1'($urandom_range(1, 0));
    for (int i = 0; i < len; i++) begin
      a = pick_element(flavor);
      b = pick_element(flavor);
      jitter = ELEMENT_WIDTH'(int'($urandom_range(2, 0)) - 1);
      case (shape)
        2: a = '0;
        3: b = '0;
        4: b = neg ? -a : a;
        5: b = neg ? -(a + jitter) : a + jitter;
        default: ;
      endcase
      add_pair(a, b, i == len - 1);
    end
  endtask

  task automatic drain;
    while (pair_queue.size() != 0 || start || pending_cosines.size() != 0)
      @(posedge clk);
  endtask

  // driver: a word stays on the ports until taken
  always @(posedge clk) begin : drive
    pair_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        fold_pair(in_first_element, in_second_element, in_last_element);
      if (!start || !busy) begin
        if (pair_queue.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          nxt = pair_queue.pop_front();
          start <= 1'b1;
          in_first_element <= nxt.first;
          in_second_element <= nxt.second;
          in_last_element <= nxt.last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    cos_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_cosines.size() == 0) begin
        $display("%0t: unexpected result cosine=%0d status=%0b", $time, out_cosine,
                 out_status);
        fail_count++;
      end else begin
        exp_res = pending_cosines.pop_front();
        if (out_cosine !== exp_res.cosine) begin
          $display("%0t: cosine expected %0d actual %0d", $time, exp_res.cosine,
                   out_cosine);
          fail_count++;
        end
        if (out_status !== exp_res.status) begin
          $display("%0t: status expected %0b actual %0b", $time, exp_res.status,
                   out_status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("cosine_similarity verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int idle_plan[4] = '{0, 84, 22, 0};
    int added, len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-pair extremes
    add_pair(32767, 32767, 1);
    add_pair(-32768, 32767, 1);
    add_pair(-32768, -32768, 1);
    add_pair(32767, -32768, 1);
    // zero norm on either side and both
    add_pair(0, 5, 1);
    add_pair(-7, 0, 1);
    add_pair(0, 0, 0);
    add_pair(0, 0, 1);
    // floor roots push the quotient past one
    add_pair(1, 1, 0);
    add_pair(1, 1, 1);
    add_pair(1, -1, 0);
    add_pair(1, -1, 0);
    add_pair(1, -1, 1);
    // orthogonal, then mixed extremes, then orthogonal again
    add_pair(1, 0, 0);
    add_pair(0, 1, 1);
    add_pair(32767, -32768, 0);
    add_pair(-32768, 32767, 0);
    add_pair(-1, 32767, 1);
    add_pair(3, 4, 0);
    add_pair(-4, 3, 1);
    drain();

    for (int ph = 1; ph < 4; ph++) begin
      sender_idle_pct <= idle_plan[ph];
      added = 0;
      while (added < RANDOM_PER_PH) begin
        add_random_vector(len);
        added += len;
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_cosines.size() == 0)
      $display("cosine_similarity verification clean");
    else
      $display("cosine_similarity verification failed");
    $finish;
  end

endmodule

`default_nettype wire
